FILE: rtl/core/mutual_match_ratio_filter_macros.svh
// assertion macros for the mutual match ratio filter
`ifndef MUTUAL_MATCH_RATIO_FILTER_MACROS_SVH
`define MUTUAL_MATCH_RATIO_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, off during reset
`define MMRF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mmrf assertion failed");

// next-cycle implication, off during reset
`define MMRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mmrf assertion failed");

`else

`define MMRF_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MMRF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/mmrf_pkg.sv
// shared types and constants of the mutual match ratio filter
package mmrf_pkg;

   localparam int MAX_KEYPOINTS = 1024;
   localparam int ADDR_W        = $clog2(MAX_KEYPOINTS);
   localparam int KEY_W         = 10;
   localparam int DIST_W        = 9;
   localparam int RATIO_W       = 9;
   localparam int CMD_W         = 2;
   localparam int PROD_W        = DIST_W + RATIO_W;
   localparam int Q_DEPTH       = 4;
   localparam int Q_PTR_W       = $clog2(Q_DEPTH);

   localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd179;

   // input command codes
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TEST  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // work carried from front to back
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_TEST,
      OP_CLEAR
   } mmrf_op_type;

   typedef struct packed {
      mmrf_op_type       op;
      logic [KEY_W-1:0]  query;
      logic [KEY_W-1:0]  train;
      logic [DIST_W-1:0] best;
   } mmrf_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mmrf_q_status_type;

   typedef struct packed {
      logic pop;
      logic clearing;
      logic init_done;
   } mmrf_back_status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COMPARE
   } mmrf_state_type;

endpackage

FILE: rtl/core/mmrf_front.sv
// front end: ratio test and classification of incoming items
module mmrf_front
   import mmrf_pkg::*;
(
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [KEY_W-1:0]     req_query_index,
   input  logic [KEY_W-1:0]     req_train_index,
   input  logic [DIST_W-1:0]    req_best_distance,
   input  logic [DIST_W-1:0]    req_second_distance,
   input  logic                 req_has_second,
   input  logic [RATIO_W-1:0]   ratio_q8,
   input  mmrf_q_status_type    q_status,
   input  mmrf_back_status_type back_status,
   output logic                 push,
   output mmrf_entry_type       push_entry
);

   logic [PROD_W-1:0] best_scaled;
   logic [PROD_W-1:0] ratio_scaled;
   logic              ratio_ok;
   logic              query_in_range;
   logic              train_in_range;
   logic              keep;

   // best * 256 against ratio * second
   assign best_scaled  = PROD_W'({req_best_distance, 8'b0});
   assign ratio_scaled = PROD_W'(ratio_q8) * PROD_W'(req_second_distance);
   assign ratio_ok     = req_has_second && !(best_scaled > ratio_scaled);

   assign query_in_range = 32'(req_query_index) < MAX_KEYPOINTS;
   assign train_in_range = 32'(req_train_index) < MAX_KEYPOINTS;

   assign req_ready = back_status.init_done && !q_status.full;

   // only items that change state or may give a match go to the back end
   always_comb begin
      keep          = 1'b0;
      push_entry.op = OP_CLEAR;
      unique case (req_command)
         CMD_LOAD: begin
            keep          = ratio_ok && query_in_range;
            push_entry.op = OP_LOAD;
         end
         CMD_TEST: begin
            keep          = ratio_ok && train_in_range;
            push_entry.op = OP_TEST;
         end
         CMD_CLEAR: begin
            keep          = 1'b1;
            push_entry.op = OP_CLEAR;
         end
         default: begin
            keep          = 1'b0;
            push_entry.op = OP_CLEAR;
         end
      endcase
      push_entry.query = req_query_index;
      push_entry.train = req_train_index;
      push_entry.best  = req_best_distance;
   end

   assign push = req_valid && req_ready && keep;

endmodule

FILE: rtl/core/mmrf_queue.sv
// small fifo between the front and back ends
module mmrf_queue
   import mmrf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mmrf_entry_type    push_entry,
   input  logic              pop,
   output mmrf_entry_type    head,
   output mmrf_q_status_type status
);

   mmrf_entry_type     entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff;
   logic [Q_PTR_W:0]   count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = count_ff == (Q_PTR_W+1)'(Q_DEPTH);
   assign status.empty = count_ff == '0;

endmodule

FILE: rtl/core/mmrf_back.sv
// back end: reverse table, cross check and result register
module mmrf_back
   import mmrf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  mmrf_entry_type       head,
   input  mmrf_q_status_type    q_status,
   output mmrf_back_status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KEY_W-1:0]     rsp_match_query,
   output logic [KEY_W-1:0]     rsp_match_train,
   output logic [DIST_W-1:0]    rsp_match_distance
);

   // table word: valid mark over target index
   logic [KEY_W:0]      table_mem [MAX_KEYPOINTS];
   logic [KEY_W:0]      rd_data_ff;

   mmrf_state_type      state_ff;
   mmrf_state_type      state_in;
   logic [ADDR_W-1:0]   clr_cnt_ff;
   logic [ADDR_W-1:0]   clr_cnt_in;
   logic                init_done_ff;
   logic                init_done_in;
   logic [KEY_W-1:0]    hold_query_ff;
   logic [KEY_W-1:0]    hold_query_in;
   logic [KEY_W-1:0]    hold_train_ff;
   logic [KEY_W-1:0]    hold_train_in;
   logic [DIST_W-1:0]   hold_best_ff;
   logic [DIST_W-1:0]   hold_best_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [KEY_W-1:0]    rsp_query_ff;
   logic [KEY_W-1:0]    rsp_query_in;
   logic [KEY_W-1:0]    rsp_train_ff;
   logic [KEY_W-1:0]    rsp_train_in;
   logic [DIST_W-1:0]   rsp_dist_ff;
   logic [DIST_W-1:0]   rsp_dist_in;

   logic                pop;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [KEY_W:0]      wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer: clearing sweep, table update, lookup and compare
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      init_done_in  = init_done_ff;
      hold_query_in = hold_query_ff;
      hold_train_in = hold_train_ff;
      hold_best_in  = hold_best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_query_in  = rsp_query_ff;
      rsp_train_in  = rsp_train_ff;
      rsp_dist_in   = rsp_dist_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(MAX_KEYPOINTS - 1)) begin
               state_in     = ST_IDLE;
               init_done_in = 1'b1;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               unique case (head.op)
                  OP_LOAD: begin
                     pop     = 1'b1;
                     wr_en   = 1'b1;
                     wr_addr = ADDR_W'(head.query);
                     wr_data = {1'b1, head.train};
                  end
                  OP_TEST: begin
                     if (out_free) begin
                        pop           = 1'b1;
                        rd_en         = 1'b1;
                        rd_addr       = ADDR_W'(head.train);
                        hold_query_in = head.query;
                        hold_train_in = head.train;
                        hold_best_in  = head.best;
                        state_in      = ST_COMPARE;
                     end
                  end
                  OP_CLEAR: begin
                     pop        = 1'b1;
                     clr_cnt_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_COMPARE: begin
            // entry must be marked and point back to the query
            if (rd_data_ff[KEY_W] && (rd_data_ff[KEY_W-1:0] == hold_query_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_query_in = hold_query_ff;
               rsp_train_in = hold_train_ff;
               rsp_dist_in  = hold_best_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         init_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         init_done_ff <= init_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_query_ff <= hold_query_in;
      hold_train_ff <= hold_train_in;
      hold_best_ff  <= hold_best_in;
      rsp_query_ff  <= rsp_query_in;
      rsp_train_ff  <= rsp_train_in;
      rsp_dist_ff   <= rsp_dist_in;
   end

   // reverse table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign status.pop       = pop;
   assign status.clearing  = state_ff == ST_CLEAR;
   assign status.init_done = init_done_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_query    = rsp_query_ff;
   assign rsp_match_train    = rsp_train_ff;
   assign rsp_match_distance = rsp_dist_ff;

endmodule

FILE: rtl/core/mutual_match_ratio_filter.sv
// top level of the mutual match ratio filter
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    command, query/train index, distances, has_second
//   rsp      out        rsp_valid/rsp_ready    match_query, match_train, match_distance
//   csr      in         csr_write_en           csr_write_data (ratio_q8)
//
// a load or a clear item leaves the queue as soon as it is at the head in idle; a forward
// test leaves it with its registered table read and is then compared in the compare state
// a clear item sweeps the table one entry a cycle; after reset the same sweep
// runs first, and req_ready stays low until that sweep is done; csr writes are
// taken throughout
// a test waits in the queue while a result is held and rsp_ready is low;
// the four-entry queue lets the front keep accepting meanwhile, until it is full

`include "mutual_match_ratio_filter_macros.svh"

module mutual_match_ratio_filter
   import mmrf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [KEY_W-1:0]   req_query_index,
   input  logic [KEY_W-1:0]   req_train_index,
   input  logic [DIST_W-1:0]  req_best_distance,
   input  logic [DIST_W-1:0]  req_second_distance,
   input  logic               req_has_second,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [KEY_W-1:0]   rsp_match_query,
   output logic [KEY_W-1:0]   rsp_match_train,
   output logic [DIST_W-1:0]  rsp_match_distance,
   input  logic               csr_write_en,
   input  logic [RATIO_W-1:0] csr_write_data
);

   logic [RATIO_W-1:0]   ratio_ff;
   logic [RATIO_W-1:0]   ratio_in;
   logic                 push;
   mmrf_entry_type       push_entry;
   mmrf_entry_type       head;
   mmrf_q_status_type    q_status;
   mmrf_back_status_type back_status;

   // ratio threshold register
   assign ratio_in = csr_write_en ? csr_write_data : ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RESET;
      end else begin
         ratio_ff <= ratio_in;
      end
   end

   // classify incoming items
   mmrf_front u_front (
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_query_index     (req_query_index),
      .req_train_index     (req_train_index),
      .req_best_distance   (req_best_distance),
      .req_second_distance (req_second_distance),
      .req_has_second      (req_has_second),
      .ratio_q8            (ratio_ff),
      .q_status            (q_status),
      .back_status         (back_status),
      .push                (push),
      .push_entry          (push_entry)
   );

   // decoupling queue
   mmrf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (back_status.pop),
      .head       (head),
      .status     (q_status)
   );

   // table and result
   mmrf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .q_status           (q_status),
      .status             (back_status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_match_query    (rsp_match_query),
      .rsp_match_train    (rsp_match_train),
      .rsp_match_distance (rsp_match_distance)
   );

   // checks
   `MMRF_ASSERT_IMPLIES(a_pop_not_empty, clock, reset, back_status.pop, !q_status.empty)
   `MMRF_ASSERT_IMPLIES(a_no_pop_clearing, clock, reset, back_status.clearing, !back_status.pop)
   `MMRF_ASSERT_IMPLIES(a_closed_after_reset, clock, reset, $fell(reset), !req_ready)

endmodule
